// ===== rtl/b64enc_pkg.sv =====
// Package with the shared types, constants and alphabet lookup of the base64 encoder.
`default_nettype none

package b64enc_pkg;

    // ASCII codes used by the alphabet and the padding.
    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_PLUS    = 8'd43;
    localparam logic [7:0] CHAR_SLASH   = 8'd47;
    localparam logic [7:0] CHAR_PAD     = 8'd61;

    // Number of bytes held in a group.
    localparam logic [1:0] HELD_ONE   = 2'd1;
    localparam logic [1:0] HELD_TWO   = 2'd2;
    localparam logic [1:0] HELD_THREE = 2'd3;

    // One finished group as it travels from the front to the back.
    typedef struct packed {
        logic [23:0] word;  // first byte in bits 23..16
        logic [1:0]  held;  // bytes of real data in the group
        logic        fin;   // group closes the message
    } t_group;

    // Maps a 6-bit index onto the standard alphabet.
    function automatic logic [7:0] alpha(input logic [5:0] idx);
        logic [7:0] wide;
        wide = {2'b00, idx};
        if (idx < 6'd26) begin
            alpha = CHAR_UPPER_A + wide;
        end else if (idx < 6'd52) begin
            alpha = CHAR_LOWER_A + wide - 8'd26;
        end else if (idx < 6'd62) begin
            alpha = CHAR_ZERO + wide - 8'd52;
        end else if (idx == 6'd62) begin
            alpha = CHAR_PLUS;
        end else begin
            alpha = CHAR_SLASH;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/b64enc_front.sv =====
// Front end: accepts message bytes and gathers them into 24-bit groups.
`default_nettype none

module b64enc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [7:0]        i_s_tdata,
    input  wire logic              i_s_tlast,
    input  wire logic              i_full,
    output logic                   o_push,
    output b64enc_pkg::t_group     o_group
);
    import b64enc_pkg::*;

    logic [1:0]  r_pos;
    logic [15:0] r_pend;
    logic [1:0]  n_pos;
    logic [15:0] n_pend;
    logic [23:0] word;
    logic [1:0]  held;
    logic        accept;

    assign o_s_tready = !i_full;
    assign accept     = i_s_tvalid && !i_full;

    // Place the new byte behind the held ones; position three counts as a new group.
    always_comb begin
        case (r_pos)
            2'd2: begin
                word = {r_pend, i_s_tdata};
                held = HELD_THREE;
            end
            2'd1: begin
                word = {r_pend[15:8], i_s_tdata, 8'h00};
                held = HELD_TWO;
            end
            default: begin
                word = {i_s_tdata, 16'h0000};
                held = HELD_ONE;
            end
        endcase
    end

    // A full group or a final byte sends the group to the queue.
    assign o_push        = accept && ((held == HELD_THREE) || i_s_tlast);
    assign o_group.word  = word;
    assign o_group.held  = held;
    assign o_group.fin   = i_s_tlast;

    // Next values of the gathering state.
    always_comb begin
        n_pos  = r_pos;
        n_pend = r_pend;
        if (o_push) begin
            n_pos  = 2'd0;
            n_pend = 16'h0000;
        end else if (accept) begin
            n_pos = held;
            if (held == HELD_ONE) begin
                n_pend = {i_s_tdata, 8'h00};
            end else begin
                n_pend = {r_pend[15:8], i_s_tdata};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 2'd0;
            r_pend <= 16'h0000;
        end else begin
            r_pos  <= n_pos;
            r_pend <= n_pend;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/b64enc_queue.sv =====
// Two-entry queue of finished groups between the front and the back.
`default_nettype none

module b64enc_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire b64enc_pkg::t_group i_group,
    output logic                   o_full,
    output logic                   o_valid,
    output b64enc_pkg::t_group     o_group,
    input  wire logic              i_pop
);
    import b64enc_pkg::*;

    t_group      r_mem [0:1];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_group = r_mem[r_rd_ptr];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    // The front never pushes into a full queue and the back never pops an empty one.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("group pushed into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("group popped from an empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue occupancy out of range");

endmodule

`default_nettype wire

// ===== rtl/b64enc_back.sv =====
// Back end: turns each queued group into four characters, one per unstalled cycle.
`default_nettype none

module b64enc_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire b64enc_pkg::t_group i_group,
    output logic                   o_pop,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [7:0]             o_m_tdata,
    output logic                   o_m_tlast
);
    import b64enc_pkg::*;

    t_group      r_work;
    logic        r_busy;
    logic [1:0]  r_idx;
    logic        r_out_valid;
    logic [7:0]  r_char;
    logic        r_eot;
    logic        can_load;
    logic [7:0]  char_sel;
    logic        eot_sel;

    assign can_load = !r_out_valid || i_m_tready;
    assign o_pop    = i_valid && (!r_busy || (can_load && (r_idx == 2'd3)));

    // Character for the current slot of the group, with padding for missing bytes.
    always_comb begin
        eot_sel = 1'b0;
        case (r_idx)
            2'd0: char_sel = alpha(r_work.word[23:18]);
            2'd1: char_sel = alpha(r_work.word[17:12]);
            2'd2: char_sel = (r_work.held >= HELD_TWO) ? alpha(r_work.word[11:6]) : CHAR_PAD;
            2'd3: begin
                char_sel = (r_work.held == HELD_THREE) ? alpha(r_work.word[5:0]) : CHAR_PAD;
                eot_sel  = r_work.fin;
            end
            default: char_sel = CHAR_PAD;
        endcase
    end

    // Control: step through the slots while the output register has room.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (can_load) begin
                r_out_valid <= r_busy;
                if (r_busy) begin
                    r_idx <= r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        r_busy <= 1'b0;
                    end
                end
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_work <= i_group;
        end
        if (can_load && r_busy) begin
            r_char <= char_sel;
            r_eot  <= eot_sel;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_char;
    assign o_m_tlast  = r_eot;

endmodule

`default_nettype wire

// ===== rtl/base64_stream_encoder_top.sv =====
// Top level of the streaming base64 encoder.
//
//  channel | dir | tdata                | tlast          | tuser
//  s_*     | in  | [7:0] data_byte      | final_byte     | -
//  m_*     | out | [7:0] code_char      | end_of_text    | -
//
// The front stalls only while the group queue is full.
// Each group leaves the back as four characters at one per cycle while the output
// is ready, so a long message is paced by the single character output register.
// A byte that closes a group passes through the group queue and the back's work register
// before the character output register shows its first character.
// Reset is synchronous and active low and empties the queue and all control state.
// A stalled output holds its character while the front keeps filling the queue.
`default_nettype none

module base64_stream_encoder_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  wire logic       i_s_tlast,
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] code_char
    output logic            o_m_tlast
);
    import b64enc_pkg::*;

    logic   push;
    logic   full;
    logic   q_valid;
    logic   pop;
    t_group front_group;
    t_group queue_group;

    b64enc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_full     (full),
        .o_push     (push),
        .o_group    (front_group)
    );

    b64enc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (front_group),
        .o_full  (full),
        .o_valid (q_valid),
        .o_group (queue_group),
        .i_pop   (pop)
    );

    b64enc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_group    (queue_group),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire
